/* hdl/isd_pkg.sv */
// Package for the interrupt storm detector: transfer payload types, state and
// configuration structs, command codes, register indexes and reset defaults.
// No dependencies.
package isd_pkg;

	localparam int TIME_BITS     = 32;
	localparam int POLL_BITS     = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [1:0] CMD_DELIVERY = 2'd0;
	localparam logic [1:0] CMD_POLL     = 2'd1;
	localparam logic [1:0] CMD_ADD      = 2'd2;
	localparam logic [1:0] CMD_REMOVE   = 2'd3;

	localparam logic [1:0] OUTCOME_HANDLED = 2'd0;
	localparam logic [1:0] OUTCOME_NONE    = 2'd1;

	localparam logic [1:0] FIXUP_MISROUTED = 2'd1;
	localparam logic [1:0] FIXUP_POLL      = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FIXUP_MODE     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_LEN     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BAD_MAX        = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GOOD_TICKS     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_COUNT_MIN = 3'd4;

	localparam logic [1:0]           RST_FIXUP_MODE     = 2'd0;
	localparam logic [15:0]          RST_PERIOD_LEN     = 16'd10000;
	localparam logic [15:0]          RST_BAD_MAX        = 16'd9900;
	localparam logic [30:0]          RST_GOOD_TICKS     = 31'd2500;
	localparam logic [POLL_BITS-1:0] RST_POLL_COUNT_MIN = POLL_BITS'(10000);

	localparam logic [POLL_BITS-1:0] POLL_INFINITE = {POLL_BITS{1'b1}};
	localparam logic [15:0]          COUNT_SAT     = 16'hFFFF;
	localparam logic [3:0]           MIN_DEC_SHIFT = 4'd1;
	localparam logic [3:0]           MAX_DEC_SHIFT = 4'd8;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [TIME_BITS-1:0] now;
		logic [1:0]           outcome;
		logic                 misrouted_found;
		logic                 is_shared;
	} in_t;

	typedef struct packed {
		logic disable_line;
		logic enable_line;
		logic poll_request;
		logic polling_active;
	} out_t;

	typedef struct packed {
		logic [1:0]           fixup_mode;
		logic [15:0]          period_len;
		logic [15:0]          bad_max;
		logic [30:0]          good_ticks;
		logic [POLL_BITS-1:0] poll_count_min;
		logic [4:0]           dur_log;
	} cfg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] epoch_tick;
		logic [15:0]          sample_count;
		logic [15:0]          bad_count;
		logic [POLL_BITS-1:0] poll_count;
		logic [POLL_BITS-1:0] polls_left;
		logic                 storm_disabled;
	} state_t;

	// smallest n with 2^n >= v; 0 for v of 0 or 1
	function automatic logic [4:0] ceil_log2(input logic [30:0] v);
		logic [30:0] vm;
		logic [4:0]  n;
		vm = v - 31'd1;
		n  = 5'd0;
		if (v > 31'd1) begin
			for (int i = 0; i < 31; i++) begin
				if (vm[i]) begin
					n = 5'(i + 1);
				end
			end
		end
		return n;
	endfunction

	localparam logic [4:0] RST_DUR_LOG = ceil_log2(RST_GOOD_TICKS);

endpackage

/* hdl/irq_storm_detector.sv */
// Interrupt storm detector, top level: input register, step logic, result register.
// Each item passes through the input register, then the result register, at one item per cycle
// unless the result stalls; a stalled result lets one more item wait in the input register.
// Reset (arst_n low): registers to defaults, detector state and valids cleared.
// Depends on isd_pkg and isd_step.
module irq_storm_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  isd_pkg::in_t                         in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output isd_pkg::out_t                        out_data,
	input  logic                                 cfg_we,
	input  logic [isd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [isd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
	import isd_pkg::*;

	logic   valid_s1;
	in_t    item_s1;
	logic   adv;
	state_t st_q;
	state_t st_nxt;
	cfg_t   cfg_q;
	out_t   res;
	out_t   out_q;
	logic   out_valid_q;

	assign adv      = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	isd_step u_step (
		.st   (st_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fixup_mode     <= RST_FIXUP_MODE;
			cfg_q.period_len     <= RST_PERIOD_LEN;
			cfg_q.bad_max        <= RST_BAD_MAX;
			cfg_q.good_ticks     <= RST_GOOD_TICKS;
			cfg_q.poll_count_min <= RST_POLL_COUNT_MIN;
			cfg_q.dur_log        <= RST_DUR_LOG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIXUP_MODE: cfg_q.fixup_mode <= cfg_wdata[1:0];
				CFG_PERIOD_LEN: cfg_q.period_len <= cfg_wdata[15:0];
				CFG_BAD_MAX:    cfg_q.bad_max    <= cfg_wdata[15:0];
				CFG_GOOD_TICKS: begin
					cfg_q.good_ticks <= cfg_wdata[30:0];
					cfg_q.dur_log    <= ceil_log2(cfg_wdata[30:0]);
				end
				CFG_POLL_COUNT_MIN: cfg_q.poll_count_min <= cfg_wdata[POLL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* hdl/isd_step.sv */
// Next-state and result logic for one command of the storm detector.
// Purely combinational; depends on isd_pkg.
module isd_step (
	input  isd_pkg::state_t st,
	input  isd_pkg::cfg_t   cfg,
	input  isd_pkg::in_t    item,
	output isd_pkg::state_t nxt,
	output isd_pkg::out_t   res
);
	import isd_pkg::*;

	logic                 bad;
	logic [15:0]          bc_inc;
	logic [15:0]          sc_inc;
	logic                 period_end;
	logic [TIME_BITS-1:0] dur;
	logic [TIME_BITS-1:0] sft_raw;
	logic [3:0]           sft;
	logic                 good;
	logic [POLL_BITS-1:0] pc_shr;
	logic [POLL_BITS-1:0] cnt;
	logic [POLL_BITS-1:0] pc_grow;
	logic [POLL_BITS-1:0] pl_dec;
	logic                 dual_poll;

	assign bad = (item.outcome != OUTCOME_HANDLED) &&
		!(item.outcome == OUTCOME_NONE && cfg.fixup_mode >= FIXUP_MISROUTED &&
		  item.misrouted_found);
	assign bc_inc     = (bad && st.bad_count != COUNT_SAT) ? st.bad_count + 16'd1 : st.bad_count;
	assign sc_inc     = (st.sample_count != COUNT_SAT) ? st.sample_count + 16'd1 : st.sample_count;
	assign period_end = sc_inc >= cfg.period_len;

	assign dur     = item.now - st.epoch_tick;
	assign sft_raw = dur >> cfg.dur_log;
	always_comb begin
		priority if (sft_raw == '0) begin
			sft = MIN_DEC_SHIFT;
		end else if (sft_raw > TIME_BITS'(MAX_DEC_SHIFT)) begin
			sft = MAX_DEC_SHIFT;
		end else begin
			sft = sft_raw[3:0];
		end
	end
	assign good   = (bc_inc < cfg.bad_max) || (dur > TIME_BITS'(cfg.good_ticks));
	assign pc_shr = st.poll_count >> sft;

	assign cnt     = (st.poll_count < cfg.poll_count_min) ? cfg.poll_count_min : st.poll_count;
	assign pc_grow = (cnt > (POLL_INFINITE >> 3)) ? POLL_INFINITE : (cnt << 3);

	assign pl_dec    = (st.polls_left != POLL_INFINITE) ? st.polls_left - POLL_BITS'(1) :
		st.polls_left;
	assign dual_poll = item.is_shared && cfg.fixup_mode >= FIXUP_POLL;

	always_comb begin
		nxt = st;
		res = '0;
		unique case (item.cmd)
			CMD_DELIVERY: begin
				nxt.bad_count    = bc_inc;
				nxt.sample_count = sc_inc;
				if (period_end) begin
					nxt.epoch_tick   = item.now;
					nxt.sample_count = '0;
					nxt.bad_count    = '0;
					if (good) begin
						nxt.poll_count = pc_shr;
					end else begin
						nxt.poll_count     = pc_grow;
						nxt.storm_disabled = 1'b1;
						nxt.polls_left     = cnt;
						res.disable_line   = 1'b1;
						res.poll_request   = 1'b1;
					end
				end
			end
			CMD_POLL: begin
				if (st.polls_left != '0) begin
					nxt.polls_left = pl_dec;
					if (pl_dec != '0) begin
						res.poll_request = 1'b1;
					end else begin
						nxt.epoch_tick   = item.now;
						nxt.sample_count = '0;
						nxt.bad_count    = '0;
					end
				end
				if (nxt.polls_left == '0 && st.storm_disabled) begin
					nxt.storm_disabled = 1'b0;
					res.enable_line    = 1'b1;
				end
			end
			CMD_ADD: begin
				if (dual_poll) begin
					nxt.polls_left   = POLL_INFINITE;
					res.poll_request = 1'b1;
				end else begin
					nxt.epoch_tick   = item.now;
					nxt.sample_count = '0;
					nxt.bad_count    = '0;
					nxt.poll_count   = cfg.poll_count_min;
					nxt.polls_left   = '0;
				end
			end
			CMD_REMOVE: begin
				if (cfg.fixup_mode < FIXUP_POLL) begin
					nxt.epoch_tick   = item.now;
					nxt.sample_count = '0;
					nxt.bad_count    = '0;
					nxt.poll_count   = cfg.poll_count_min;
					nxt.polls_left   = '0;
				end
			end
		endcase
		res.polling_active = nxt.polls_left != '0;
	end

endmodule

/* hdl/isd_checker.sv */
// Port-level checks on the storm detector's result channel, and the bind
// that attaches them to irq_storm_detector. Depends on isd_pkg.
module isd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input isd_pkg::out_t out_data
);
	import isd_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// storm detection always schedules a poll
	a_disable_polls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.disable_line |-> out_data.poll_request)
		else $error("disable without poll request");

	// re-enable only once polling has finished
	a_enable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.enable_line |-> !out_data.polling_active &&
			!out_data.poll_request && !out_data.disable_line)
		else $error("enable while polling");

	// a poll request without a disable means polls remain
	a_request_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.poll_request && !out_data.disable_line |->
			out_data.polling_active)
		else $error("poll request with no polls left");

endmodule

bind irq_storm_detector isd_checker u_isd_checker (.*);

/* sim/tb.sv */
// Self-checking bench for irq_storm_detector: a scoreboard class predicts each result
// from the transfers in, plain tasks drive stimulus and registers. Depends on isd_pkg.
`timescale 1ns / 1ps

module tb;
	import isd_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 12;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4;

	localparam logic [1:0] OUTCOME_BOGUS = 2'd2;
	localparam logic [1:0] OUTCOME_UNKNOWN = 2'd3;
	localparam logic [1:0] FIXUP_DETECT = 2'd0;
	localparam logic [1:0] FIXUP_RESERVED = 2'd3;

	class storm_scoreboard;
		logic [1:0] fixup;
		logic [15:0] samples_per_period;
		logic [15:0] bad_limit;
		logic [30:0] period_ticks;
		logic [POLL_BITS-1:0] min_polls;
		logic [TIME_BITS-1:0] start_tick;
		logic [15:0] n_samples;
		logic [15:0] n_bad;
		logic [POLL_BITS-1:0] poll_budget;
		logic [POLL_BITS-1:0] polls_pending;
		logic masked;
		out_t expected_q[$];
		int failures;

		function new();
			fixup = RST_FIXUP_MODE;
			samples_per_period = RST_PERIOD_LEN;
			bad_limit = RST_BAD_MAX;
			period_ticks = RST_GOOD_TICKS;
			min_polls = RST_POLL_COUNT_MIN;
			start_tick = '0;
			n_samples = '0;
			n_bad = '0;
			poll_budget = '0;
			polls_pending = '0;
			masked = 1'b0;
			failures = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				CFG_FIXUP_MODE: fixup = data[1:0];
				CFG_PERIOD_LEN: samples_per_period = data[15:0];
				CFG_BAD_MAX: bad_limit = data[15:0];
				CFG_GOOD_TICKS: period_ticks = data[30:0];
				CFG_POLL_COUNT_MIN: min_polls = data[POLL_BITS-1:0];
				default: ;
			endcase
		endfunction

		// smallest n with 2^n >= v
		function int order_of(logic [30:0] v);
			int n;
			n = 0;
			while (n < 31 && (64'd1 << n) < v)
				n++;
			return n;
		endfunction

		function void restart_period(logic [TIME_BITS-1:0] t);
			start_tick = t;
			n_samples = '0;
			n_bad = '0;
		endfunction

		function void rearm(logic [TIME_BITS-1:0] t);
			restart_period(t);
			poll_budget = min_polls;
			polls_pending = '0;
		endfunction

		function void note(in_t item);
			out_t r;
			logic [TIME_BITS-1:0] dur;
			logic [POLL_BITS-1:0] cnt;
			logic [31:0] sft;
			logic bad;
			r = '0;
			case (item.cmd)
				CMD_DELIVERY: begin
					bad = (item.outcome != OUTCOME_HANDLED);
					if (item.outcome == OUTCOME_NONE && fixup >= FIXUP_MISROUTED &&
							item.misrouted_found)
						bad = 1'b0;
					if (bad && n_bad != COUNT_SAT)
						n_bad++;
					if (n_samples != COUNT_SAT)
						n_samples++;
					if (n_samples >= samples_per_period) begin
						dur = item.now - start_tick;
						if (n_bad < bad_limit || dur > {1'b0, period_ticks}) begin
							sft = dur >> order_of(period_ticks);
							if (sft < MIN_DEC_SHIFT)
								sft = MIN_DEC_SHIFT;
							if (sft > MAX_DEC_SHIFT)
								sft = MAX_DEC_SHIFT;
							poll_budget = poll_budget >> sft;
						end else begin
							cnt = (poll_budget < min_polls) ? min_polls : poll_budget;
							poll_budget = (cnt > (POLL_INFINITE >> 3)) ? POLL_INFINITE : cnt << 3;
							masked = 1'b1;
							polls_pending = cnt;
							r.disable_line = 1'b1;
							r.poll_request = 1'b1;
						end
						restart_period(item.now);
					end
				end
				CMD_POLL: begin
					if (polls_pending != 0) begin
						if (polls_pending != POLL_INFINITE)
							polls_pending--;
						if (polls_pending != 0)
							r.poll_request = 1'b1;
						else
							restart_period(item.now);
					end
					if (polls_pending == 0 && masked) begin
						masked = 1'b0;
						r.enable_line = 1'b1;
					end
				end
				CMD_ADD: begin
					if (item.is_shared && fixup >= FIXUP_POLL) begin
						polls_pending = POLL_INFINITE;
						r.poll_request = 1'b1;
					end else begin
						rearm(item.now);
					end
				end
				default: begin
					if (fixup < FIXUP_POLL)
						rearm(item.now);
				end
			endcase
			r.polling_active = (polls_pending != 0);
			expected_q.push_back(r);
		endfunction

		function void check(out_t got);
			out_t want;
			logic [3:0] g;
			logic [3:0] w;
			string names [4];
			names = '{"polling_active", "poll_request", "enable_line", "disable_line"};
			if (expected_q.size() == 0) begin
				$display("%0t: result %b with nothing expected", $time, got);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			g = got;
			w = want;
			for (int i = 0; i < 4; i++) begin
				if (g[i] !== w[i]) begin
					$display("%0t: %s expected %b actual %b", $time, names[i], w[i], g[i]);
					failures++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	storm_scoreboard sb;
	int src_idle = 0;
	int dst_idle = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;
	int quiet = 0;
	logic [TIME_BITS-1:0] tick_now = '0;

	irq_storm_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < dst_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note(in_data);
			if (out_valid && !out_stall)
				sb.check(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send_item(input in_t item);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic put(input logic [1:0] cmd, input logic [TIME_BITS-1:0] t,
			input logic [1:0] outcome, input logic found, input logic shared);
		in_t item;
		item.cmd = cmd;
		item.now = t;
		item.outcome = outcome;
		item.misrouted_found = found;
		item.is_shared = shared;
		send_item(item);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(input logic [1:0] fixup, input logic [15:0] samples,
			input logic [15:0] thresh, input logic [30:0] ticks,
			input logic [POLL_BITS-1:0] min_polls);
		write_reg(CFG_FIXUP_MODE, CFG_DATA_BITS'(fixup));
		write_reg(CFG_PERIOD_LEN, CFG_DATA_BITS'(samples));
		write_reg(CFG_BAD_MAX, CFG_DATA_BITS'(thresh));
		write_reg(CFG_GOOD_TICKS, CFG_DATA_BITS'(ticks));
		write_reg(CFG_POLL_COUNT_MIN, CFG_DATA_BITS'(min_polls));
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [1:0] fixup, input logic [15:0] samples,
			input logic [15:0] thresh, input logic [30:0] ticks,
			input logic [POLL_BITS-1:0] min_polls, input int bad_pct, input int step_max,
			input int items, input int src_pct, input int dst_pct);
		in_t item;
		int pick;
		src_idle = src_pct;
		dst_idle = dst_pct;
		configure(fixup, samples, thresh, ticks, min_polls);
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(99);
			if (pick < 65)
				item.cmd = CMD_DELIVERY;
			else if (pick < 88)
				item.cmd = CMD_POLL;
			else if (pick < 94)
				item.cmd = CMD_ADD;
			else
				item.cmd = CMD_REMOVE;
			if ($urandom_range(99) < 3)
				tick_now = $urandom;
			else
				tick_now = tick_now + TIME_BITS'($urandom_range(step_max));
			item.now = tick_now;
			if ($urandom_range(99) < bad_pct)
				item.outcome = 2'($urandom_range(OUTCOME_NONE, OUTCOME_UNKNOWN));
			else
				item.outcome = OUTCOME_HANDLED;
			item.misrouted_found = 1'($urandom_range(1));
			item.is_shared = 1'($urandom_range(1));
			send_item(item);
		end
		drain();
	endtask

	initial begin
		sb = new();
		src_idle = 25;
		dst_idle = 60;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset
		put(CMD_DELIVERY, '0, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_DELIVERY, '1, OUTCOME_UNKNOWN, 1'b1, 1'b1);
		put(CMD_POLL, 32'd1, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_ADD, 32'd2, OUTCOME_BOGUS, 1'b0, 1'b1);
		put(CMD_REMOVE, 32'd3, OUTCOME_NONE, 1'b1, 1'b0);
		drain();

		// one-sample periods, zero duration: equal timestamps give a storm
		configure(FIXUP_POLL, 16'd1, 16'd1, 31'd0, 32'd2);
		put(CMD_DELIVERY, 32'd100, OUTCOME_NONE, 1'b1, 1'b0);
		put(CMD_DELIVERY, 32'd100, OUTCOME_BOGUS, 1'b0, 1'b0);
		put(CMD_DELIVERY, 32'd100, OUTCOME_UNKNOWN, 1'b0, 1'b0);
		put(CMD_POLL, 32'd101, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_POLL, 32'd102, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_ADD, 32'd103, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_POLL, 32'd104, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_DELIVERY, 32'd104, OUTCOME_NONE, 1'b0, 1'b0);
		put(CMD_ADD, 32'd105, OUTCOME_HANDLED, 1'b0, 1'b1);
		put(CMD_POLL, 32'd106, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_REMOVE, 32'd107, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_DELIVERY, 32'd105, OUTCOME_BOGUS, 1'b1, 1'b0);
		put(CMD_POLL, 32'd108, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_DELIVERY, '0, OUTCOME_HANDLED, 1'b0, 1'b0);
		put(CMD_POLL, '1, OUTCOME_HANDLED, 1'b0, 1'b0);
		drain();

		run_phase(FIXUP_MISROUTED, 16'd4, 16'd2, 31'd20, 32'd2, 70, 3, 200, 25, 60);
		run_phase(FIXUP_POLL, 16'd1, 16'd1, 31'd1, 32'd1, 50, 2, 200, 25, 60);
		run_phase(FIXUP_DETECT, 16'd0, 16'd0, 31'd0, 32'd3, 40, 1, 150, 25, 60);
		run_phase(FIXUP_RESERVED, 16'd8, 16'd5, 31'h7FFFFFFF, 32'd1, 80, 5000, 150, 60, 25);
		run_phase(FIXUP_MISROUTED, 16'hFFFF, 16'hFFFF, 31'd1000, 32'd5, 50, 2, 100, 60, 25);
		run_phase(FIXUP_DETECT, 16'd2, 16'd0, 31'd3, '1, 60, 2, 120, 60, 25);
		run_phase(FIXUP_POLL, 16'd3, 16'd2, 31'd10, 32'd0, 60, 4, 140, 0, 0);
		hold_req = 1'b1;
		run_phase(FIXUP_MISROUTED, 16'd2, 16'd1, 31'd8, 32'd2, 60, 3, 150, 0, 0);

		if (sb.pending() != 0)
			$display("%0t: %0d results never arrived", $time, sb.pending());
		if (sb.failures == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
